// ----- rtl/length_prefixed_frame_parser_core_macros.svh -----
// Assertion macros shared by the frame parser RTL
`ifndef LENGTH_PREFIXED_FRAME_PARSER_CORE_MACROS_SVH
`define LENGTH_PREFIXED_FRAME_PARSER_CORE_MACROS_SVH

// checked only outside reset
`define LFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every edge, reset included
`define LFP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- rtl/lfp_pkg.sv -----
// Types and constants of the length-prefixed frame parser
`default_nettype none
package lfp_pkg;

  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DAT_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CLIP    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HELLO_CODE  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_CODE   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNCED_CODE = 8'd3;

  localparam logic [31:0] MAX_CLIP_RST    = 32'd1048576;
  localparam logic [7:0]  HELLO_CODE_RST  = 8'd1;
  localparam logic [7:0]  CLIP_CODE_RST   = 8'd2;
  localparam logic [7:0]  SYNCED_CODE_RST = 8'd3;

  localparam logic [32:0] LIMIT_OVERHEAD = 33'd64;
  localparam logic [32:0] MIME_ALLOWANCE = 33'h0ffff;

  localparam logic [31:0] LEN_BYTES      = 32'd4;
  localparam logic [31:0] HELLO_HDR_LEN  = 32'd6;
  localparam logic [31:0] CLIP_TIME_LEN  = 32'd8;
  localparam logic [31:0] CLIP_FLAGS_POS = 32'd9;
  localparam logic [31:0] CLIP_HDR_LEN   = 32'd11;

  localparam int unsigned OQ_DEPTH = 4;
  localparam int unsigned OQ_PTR_W = 2;
  localparam int unsigned OQ_CNT_W = 3;

  typedef enum logic [7:0] {
    ST_LEN       = 8'b0000_0001,
    ST_HELLO_HDR = 8'b0000_0010,
    ST_NAME      = 8'b0000_0100,
    ST_CLIP_HDR  = 8'b0000_1000,
    ST_MIME      = 8'b0001_0000,
    ST_DATA      = 8'b0010_0000,
    ST_SYNCED    = 8'b0100_0000,
    ST_SKIP      = 8'b1000_0000
  } stage_e;

  typedef enum logic [2:0] {
    EV_HELLO = 3'd0,
    EV_NAME  = 3'd1,
    EV_CLIP  = 3'd2,
    EV_MIME  = 3'd3,
    EV_DATA  = 3'd4,
    EV_END   = 3'd5,
    EV_ERROR = 3'd6
  } event_e;

  typedef struct packed {
    logic [31:0] max_clip;
    logic [7:0]  hello_code;
    logic [7:0]  clip_code;
    logic [7:0]  synced_code;
  } cfg_t;

  typedef struct packed {
    event_e             event_res;
    logic [15:0]        version;
    logic [31:0]        peer_max_clip;
    logic signed [63:0] clip_time;
    logic [7:0]         clip_flags;
    logic [15:0]        mime_length;
    logic [7:0]         payload_byte;
    logic [7:0]         frame_type;
    logic               last;
  } result_t;

  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } burst_t;

endpackage
`default_nettype wire

// ----- rtl/lfp_parser.sv -----
// Per-byte frame parser: position tracking, field assembly, result generation
`default_nettype none
`include "length_prefixed_frame_parser_core_macros.svh"
module lfp_parser (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           step_i,
  input  wire logic [7:0]     byte_i,
  input  wire lfp_pkg::cfg_t  cfg_i,
  output lfp_pkg::burst_t     burst_o
);

  lfp_pkg::stage_e stage_q, stage_d;
  logic [31:0] bc_q, bc_d;
  logic [31:0] flen_q, flen_d;
  logic [7:0]  ctype_q, ctype_d;
  logic [63:0] fs_q, fs_d;
  logic [15:0] mime_q, mime_d;
  logic        broken_q, broken_d;
  logic [7:0]  flags_q, flags_d;

  logic [31:0] len;
  logic [32:0] lim;
  logic        f_vld, e_vld;
  lfp_pkg::result_t field_rec, end_rec;

  assign len = {fs_q[23:0], byte_i};
  assign lim = {1'b0, cfg_i.max_clip} + lfp_pkg::LIMIT_OVERHEAD + lfp_pkg::MIME_ALLOWANCE;

  always_comb begin
    stage_d  = stage_q;
    bc_d     = bc_q;
    flen_d   = flen_q;
    ctype_d  = ctype_q;
    fs_d     = fs_q;
    mime_d   = mime_q;
    broken_d = broken_q;
    flags_d  = flags_q;
    f_vld    = 1'b0;
    e_vld    = 1'b0;
    field_rec = '0;
    end_rec   = '0;

    if (step_i && !broken_q) begin
      if (stage_q == lfp_pkg::ST_LEN && bc_q < lfp_pkg::LEN_BYTES) begin
        fs_d = {32'd0, len};
        bc_d = bc_q + 32'd1;
        if (bc_d == lfp_pkg::LEN_BYTES) begin
          if (len == 32'd0 || {1'b0, len} > lim) begin
            broken_d = 1'b1;
          end else begin
            flen_d = len;
            fs_d   = '0;
          end
        end
      end else begin
        if (stage_q == lfp_pkg::ST_LEN) begin
          ctype_d = byte_i;
          bc_d    = 32'd1;
          fs_d    = '0;
          mime_d  = '0;
          flags_d = '0;
          priority if (byte_i == cfg_i.hello_code) begin
            stage_d = lfp_pkg::ST_HELLO_HDR;
          end else if (byte_i == cfg_i.clip_code) begin
            stage_d = lfp_pkg::ST_CLIP_HDR;
          end else if (byte_i == cfg_i.synced_code) begin
            stage_d = lfp_pkg::ST_SYNCED;
          end else begin
            stage_d = lfp_pkg::ST_SKIP;
          end
        end else begin
          bc_d = bc_q + 32'd1;
          unique case (stage_q)
            lfp_pkg::ST_HELLO_HDR: begin
              fs_d = {fs_q[55:0], byte_i};
              if (bc_q == lfp_pkg::HELLO_HDR_LEN) begin
                f_vld                   = 1'b1;
                field_rec.event_res     = lfp_pkg::EV_HELLO;
                field_rec.version       = fs_d[47:32];
                field_rec.peer_max_clip = fs_d[31:0];
                stage_d                 = lfp_pkg::ST_NAME;
              end
            end
            lfp_pkg::ST_CLIP_HDR: begin
              if (bc_q <= lfp_pkg::CLIP_TIME_LEN) begin
                fs_d = {fs_q[55:0], byte_i};
              end else if (bc_q == lfp_pkg::CLIP_FLAGS_POS) begin
                flags_d = byte_i;
              end else begin
                mime_d = {mime_q[7:0], byte_i};
              end
              if (bc_q == lfp_pkg::CLIP_HDR_LEN) begin
                f_vld                 = 1'b1;
                field_rec.event_res   = lfp_pkg::EV_CLIP;
                field_rec.clip_time   = fs_d;
                field_rec.clip_flags  = flags_d;
                field_rec.mime_length = mime_d;
                stage_d = (mime_d != 16'd0) ? lfp_pkg::ST_MIME : lfp_pkg::ST_DATA;
              end
            end
            lfp_pkg::ST_NAME: begin
              f_vld                  = 1'b1;
              field_rec.event_res    = lfp_pkg::EV_NAME;
              field_rec.payload_byte = byte_i;
            end
            lfp_pkg::ST_MIME: begin
              f_vld                  = 1'b1;
              field_rec.event_res    = lfp_pkg::EV_MIME;
              field_rec.payload_byte = byte_i;
              mime_d                 = mime_q - 16'd1;
              if (mime_d == 16'd0) begin
                stage_d = lfp_pkg::ST_DATA;
              end
            end
            lfp_pkg::ST_DATA: begin
              f_vld                  = 1'b1;
              field_rec.event_res    = lfp_pkg::EV_DATA;
              field_rec.payload_byte = byte_i;
            end
            default: begin
            end
          endcase
        end

        if (bc_d == flen_q) begin
          if (stage_d == lfp_pkg::ST_HELLO_HDR || stage_d == lfp_pkg::ST_CLIP_HDR ||
              stage_d == lfp_pkg::ST_MIME) begin
            e_vld             = 1'b1;
            end_rec.event_res = lfp_pkg::EV_ERROR;
            broken_d          = 1'b1;
          end else if (stage_d != lfp_pkg::ST_SKIP) begin
            e_vld             = 1'b1;
            end_rec.event_res = lfp_pkg::EV_END;
          end
          stage_d = lfp_pkg::ST_LEN;
          bc_d    = '0;
          fs_d    = '0;
          mime_d  = '0;
        end
      end
    end

    field_rec.frame_type = ctype_d;
    end_rec.frame_type   = ctype_d;
    field_rec.last       = !e_vld;
    end_rec.last         = 1'b1;
  end

  assign burst_o.n  = {1'b0, f_vld} + {1'b0, e_vld};
  assign burst_o.r0 = f_vld ? field_rec : end_rec;
  assign burst_o.r1 = end_rec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q  <= lfp_pkg::ST_LEN;
      bc_q     <= '0;
      flen_q   <= '0;
      ctype_q  <= '0;
      fs_q     <= '0;
      mime_q   <= '0;
      broken_q <= 1'b0;
      flags_q  <= '0;
    end else begin
      stage_q  <= stage_d;
      bc_q     <= bc_d;
      flen_q   <= flen_d;
      ctype_q  <= ctype_d;
      fs_q     <= fs_d;
      mime_q   <= mime_d;
      broken_q <= broken_d;
      flags_q  <= flags_d;
    end
  end

  `LFP_ASSERT(a_broken_sticky, broken_q |=> broken_q, "broken state cleared without reset")
  `LFP_ASSERT(a_broken_silent, (step_i && broken_q) |-> (burst_o.n == 2'd0),
    "result produced while broken")
  `LFP_ASSERT(a_pair_tail, (burst_o.n == 2'd2) |-> (burst_o.r1.event_res == lfp_pkg::EV_END ||
    burst_o.r1.event_res == lfp_pkg::EV_ERROR), "second result is not frame end or error")

endmodule
`default_nettype wire

// ----- rtl/lfp_outq.sv -----
// Result queue: takes up to two results per cycle, delivers one per transfer
`default_nettype none
`include "length_prefixed_frame_parser_core_macros.svh"
module lfp_outq (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire lfp_pkg::burst_t  burst_i,
  output logic                  space_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output lfp_pkg::result_t      head_o
);

  lfp_pkg::result_t mem_q [lfp_pkg::OQ_DEPTH];
  logic [lfp_pkg::OQ_PTR_W-1:0] wr_q, wr_d, rd_q, rd_d, wr_nxt;
  logic [lfp_pkg::OQ_CNT_W-1:0] cnt_q, cnt_d;
  logic pop;

  assign space_o     = cnt_q <= lfp_pkg::OQ_CNT_W'(lfp_pkg::OQ_DEPTH - 2);
  assign out_valid_o = cnt_q != '0;
  assign pop         = out_valid_o && !out_stall_i;
  assign head_o      = mem_q[rd_q];
  assign wr_nxt      = wr_q + lfp_pkg::OQ_PTR_W'(1);

  always_comb begin
    wr_d  = wr_q + lfp_pkg::OQ_PTR_W'(burst_i.n);
    rd_d  = rd_q + lfp_pkg::OQ_PTR_W'(pop);
    cnt_d = cnt_q + lfp_pkg::OQ_CNT_W'(burst_i.n) - lfp_pkg::OQ_CNT_W'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (burst_i.n != 2'd0) begin
      mem_q[wr_q] <= burst_i.r0;
    end
    if (burst_i.n == 2'd2) begin
      mem_q[wr_nxt] <= burst_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  `LFP_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= lfp_pkg::OQ_CNT_W'(lfp_pkg::OQ_DEPTH),
    "queue count above depth")
  `LFP_ASSERT(a_push_room, (burst_i.n != 2'd0) |-> space_o, "push into a full queue")
  `LFP_ASSERT(a_hold_valid, (out_valid_o && out_stall_i) |=> out_valid_o,
    "stalled result dropped")

endmodule
`default_nettype wire

// ----- rtl/length_prefixed_frame_parser_core.sv -----
// Frame parser top: byte input register, config registers, parser, result queue
// Data path: an accepted byte is held in the input register until the result queue has room,
//   is then parsed, and its results are registered into the queue, whose head drives the outputs.
// Throughput: one byte per cycle while the result queue has room; a byte that ends a frame
//   behind a field event yields two results, which leave one at a time by the single output port.
// Reset: asynchronous, active low; parser waits for length bytes, config at defaults.
`default_nettype none
module length_prefixed_frame_parser_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [7:0]                    rx_byte_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [2:0]                         event_res_o,
  output logic [15:0]                        version_o,
  output logic [31:0]                        peer_max_clip_o,
  output logic signed [63:0]                 clip_time_o,
  output logic [7:0]                         clip_flags_o,
  output logic [15:0]                        mime_length_o,
  output logic [7:0]                         payload_byte_o,
  output logic [7:0]                         frame_type_o,
  output logic                               last_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [lfp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [lfp_pkg::CFG_DAT_W-1:0] cfg_data_i
);

  lfp_pkg::cfg_t    cfg_q;
  lfp_pkg::burst_t  burst;
  lfp_pkg::result_t head;
  logic       in_vld_q, in_vld_d;
  logic [7:0] in_byte_q;
  logic       space, consume, in_acc;

  assign cfg_ready_o = 1'b1;
  assign consume     = in_vld_q && space;
  assign in_stall_o  = in_vld_q && !space;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign in_vld_d    = in_acc ? 1'b1 : (consume ? 1'b0 : in_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_byte_q <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_clip    <= lfp_pkg::MAX_CLIP_RST;
      cfg_q.hello_code  <= lfp_pkg::HELLO_CODE_RST;
      cfg_q.clip_code   <= lfp_pkg::CLIP_CODE_RST;
      cfg_q.synced_code <= lfp_pkg::SYNCED_CODE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        lfp_pkg::CFG_MAX_CLIP:    cfg_q.max_clip    <= cfg_data_i;
        lfp_pkg::CFG_HELLO_CODE:  cfg_q.hello_code  <= cfg_data_i[7:0];
        lfp_pkg::CFG_CLIP_CODE:   cfg_q.clip_code   <= cfg_data_i[7:0];
        lfp_pkg::CFG_SYNCED_CODE: cfg_q.synced_code <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  lfp_parser u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (consume),
    .byte_i  (in_byte_q),
    .cfg_i   (cfg_q),
    .burst_o (burst)
  );

  lfp_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .burst_i     (burst),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .head_o      (head)
  );

  assign event_res_o     = head.event_res;
  assign version_o       = head.version;
  assign peer_max_clip_o = head.peer_max_clip;
  assign clip_time_o     = head.clip_time;
  assign clip_flags_o    = head.clip_flags;
  assign mime_length_o   = head.mime_length;
  assign payload_byte_o  = head.payload_byte;
  assign frame_type_o    = head.frame_type;
  assign last_o          = head.last;

endmodule
`default_nettype wire

// ----- verif/tb_length_prefixed_frame_parser_core.sv -----
// Testbench for the length-prefixed frame parser: byte stream in, predicted events checked out
`default_nettype none
module tb_length_prefixed_frame_parser_core;

  localparam int STALL_LIMIT = 5000;
  localparam int LONG_HOLD = 400;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  logic [7:0]                    rx_byte_i = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic [2:0]                    event_res_o;
  logic [15:0]                   version_o;
  logic [31:0]                   peer_max_clip_o;
  logic signed [63:0]            clip_time_o;
  logic [7:0]                    clip_flags_o;
  logic [15:0]                   mime_length_o;
  logic [7:0]                    payload_byte_o;
  logic [7:0]                    frame_type_o;
  logic                          last_o;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [lfp_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [lfp_pkg::CFG_DAT_W-1:0] cfg_data_i = '0;

  length_prefixed_frame_parser_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .event_res_o    (event_res_o),
    .version_o      (version_o),
    .peer_max_clip_o(peer_max_clip_o),
    .clip_time_o    (clip_time_o),
    .clip_flags_o   (clip_flags_o),
    .mime_length_o  (mime_length_o),
    .payload_byte_o (payload_byte_o),
    .frame_type_o   (frame_type_o),
    .last_o         (last_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // shadow of the configuration registers
  logic [31:0] max_clip_q    = lfp_pkg::MAX_CLIP_RST;
  logic [7:0]  hello_code_q  = lfp_pkg::HELLO_CODE_RST;
  logic [7:0]  clip_code_q   = lfp_pkg::CLIP_CODE_RST;
  logic [7:0]  synced_code_q = lfp_pkg::SYNCED_CODE_RST;

  // parser state as predicted
  lfp_pkg::stage_e fr_stage = lfp_pkg::ST_LEN;
  logic [31:0]     fr_count = '0;
  logic [31:0]     fr_len = '0;
  logic [7:0]      fr_type = '0;
  logic [63:0]     fr_shift = '0;
  logic [15:0]     fr_mime_left = '0;
  logic [7:0]      fr_flags = '0;
  bit              stream_broken = 1'b0;

  logic [7:0]       rx_stream[$];
  lfp_pkg::result_t expected_events[$];
  int               bytes_queued = 0;
  int               mismatches = 0;
  int               idle_cycles = 0;
  bit               idle_on = 1'b1;
  bit               long_hold_req = 1'b0;
  bit               long_hold_done = 1'b0;
  int               hold_left = 0;
  int               in_gap = 0;
  int               in_calm = 0;
  int               out_gap = 0;
  int               out_calm = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic lfp_pkg::stage_e classify(input logic [7:0] t);
    if (t == hello_code_q) return lfp_pkg::ST_HELLO_HDR;
    if (t == clip_code_q) return lfp_pkg::ST_CLIP_HDR;
    if (t == synced_code_q) return lfp_pkg::ST_SYNCED;
    return lfp_pkg::ST_SKIP;
  endfunction

  function automatic lfp_pkg::result_t blank_event(input lfp_pkg::event_e ev);
    lfp_pkg::result_t r;
    r = '0;
    r.event_res = ev;
    r.frame_type = fr_type;
    return r;
  endfunction

  task automatic parse_rx_byte(input logic [7:0] b);
    lfp_pkg::result_t ev[2];
    int               n;
    logic [31:0]      pos;
    logic [32:0]      lim;
    n = 0;
    if (stream_broken) return;
    if (fr_stage == lfp_pkg::ST_LEN && fr_count < lfp_pkg::LEN_BYTES) begin
      fr_shift = {32'd0, fr_shift[23:0], b};
      fr_count++;
      if (fr_count == lfp_pkg::LEN_BYTES) begin
        lim = {1'b0, max_clip_q} + lfp_pkg::LIMIT_OVERHEAD + lfp_pkg::MIME_ALLOWANCE;
        if (fr_shift[31:0] == 32'd0 || {1'b0, fr_shift[31:0]} > lim) begin
          stream_broken = 1'b1;
          return;
        end
        fr_len = fr_shift[31:0];
        fr_shift = '0;
      end
      return;
    end
    if (fr_stage == lfp_pkg::ST_LEN) begin
      fr_type = b;
      fr_count = 32'd1;
      fr_shift = '0;
      fr_mime_left = '0;
      fr_flags = '0;
      fr_stage = classify(b);
    end else begin
      pos = fr_count - 32'd1;
      fr_count++;
      case (fr_stage)
        lfp_pkg::ST_HELLO_HDR: begin
          fr_shift = {fr_shift[55:0], b};
          if (pos == lfp_pkg::HELLO_HDR_LEN - 32'd1) begin
            ev[n] = blank_event(lfp_pkg::EV_HELLO);
            ev[n].version = fr_shift[47:32];
            ev[n].peer_max_clip = fr_shift[31:0];
            n++;
            fr_stage = lfp_pkg::ST_NAME;
          end
        end
        lfp_pkg::ST_NAME: begin
          ev[n] = blank_event(lfp_pkg::EV_NAME);
          ev[n].payload_byte = b;
          n++;
        end
        lfp_pkg::ST_CLIP_HDR: begin
          if (pos < lfp_pkg::CLIP_TIME_LEN) fr_shift = {fr_shift[55:0], b};
          else if (pos == lfp_pkg::CLIP_TIME_LEN) fr_flags = b;
          else fr_mime_left = {fr_mime_left[7:0], b};
          if (pos == lfp_pkg::CLIP_HDR_LEN - 32'd1) begin
            ev[n] = blank_event(lfp_pkg::EV_CLIP);
            ev[n].clip_time = fr_shift;
            ev[n].clip_flags = fr_flags;
            ev[n].mime_length = fr_mime_left;
            n++;
            if (fr_mime_left != 16'd0) fr_stage = lfp_pkg::ST_MIME;
            else fr_stage = lfp_pkg::ST_DATA;
          end
        end
        lfp_pkg::ST_MIME: begin
          ev[n] = blank_event(lfp_pkg::EV_MIME);
          ev[n].payload_byte = b;
          n++;
          fr_mime_left--;
          if (fr_mime_left == 16'd0) fr_stage = lfp_pkg::ST_DATA;
        end
        lfp_pkg::ST_DATA: begin
          ev[n] = blank_event(lfp_pkg::EV_DATA);
          ev[n].payload_byte = b;
          n++;
        end
        default: begin
        end
      endcase
    end
    if (fr_count == fr_len) begin
      if (fr_stage == lfp_pkg::ST_HELLO_HDR || fr_stage == lfp_pkg::ST_CLIP_HDR ||
          fr_stage == lfp_pkg::ST_MIME) begin
        ev[n] = blank_event(lfp_pkg::EV_ERROR);
        n++;
        stream_broken = 1'b1;
      end else if (fr_stage != lfp_pkg::ST_SKIP) begin
        ev[n] = blank_event(lfp_pkg::EV_END);
        n++;
      end
      fr_stage = lfp_pkg::ST_LEN;
      fr_count = '0;
      fr_shift = '0;
      fr_mime_left = '0;
    end
    if (n > 0) ev[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) expected_events.insert(expected_events.size(), ev[i]);
  endtask

  task automatic cmp_field(input string fname, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t %s: expected %h, actual %h", $time, fname, want, got);
    end
  endtask

  task automatic check_event();
    lfp_pkg::result_t e;
    if (expected_events.size() == 0) begin
      mismatches++;
      $display("%0t unexpected result: expected none, actual event %0d type %h",
               $time, event_res_o, frame_type_o);
      return;
    end
    e = expected_events.pop_front();
    cmp_field("event_res", 64'(e.event_res), 64'(event_res_o));
    cmp_field("version", 64'(e.version), 64'(version_o));
    cmp_field("peer_max_clip", 64'(e.peer_max_clip), 64'(peer_max_clip_o));
    cmp_field("clip_time", 64'(e.clip_time), 64'(clip_time_o));
    cmp_field("clip_flags", 64'(e.clip_flags), 64'(clip_flags_o));
    cmp_field("mime_length", 64'(e.mime_length), 64'(mime_length_o));
    cmp_field("payload_byte", 64'(e.payload_byte), 64'(payload_byte_o));
    cmp_field("frame_type", 64'(e.frame_type), 64'(frame_type_o));
    cmp_field("last", 64'(e.last), 64'(last_o));
  endtask

  // byte driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) parse_rx_byte(rx_byte_i);
      if (!in_valid_i || !in_stall_o) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (idle_on && in_calm == 0 && $urandom_range(0, 9) == 0) begin
          in_gap = int'($urandom_range(0, 18));
          in_calm = int'($urandom_range(0, 60));
          in_valid_i <= 1'b0;
        end else if (rx_stream.size() > 0) begin
          if (in_calm > 0) in_calm--;
          in_valid_i <= 1'b1;
          rx_byte_i <= rx_stream.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // event monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) check_event();
      if (long_hold_req && !long_hold_done) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (out_gap > 0) begin
        out_gap--;
        out_stall_i <= 1'b1;
      end else if (idle_on && out_calm == 0 && $urandom_range(0, 9) == 0) begin
        out_gap = int'($urandom_range(0, 18));
        out_calm = int'($urandom_range(0, 60));
        out_stall_i <= 1'b1;
      end else begin
        if (out_calm > 0) out_calm--;
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles == STALL_LIMIT) begin
      $display("FAIL length_prefixed_frame_parser_core");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] b);
    rx_stream.insert(rx_stream.size(), b);
    bytes_queued++;
  endtask

  task automatic push_be(input logic [63:0] v, input int nbytes);
    for (int i = nbytes - 1; i >= 0; i--) push_byte(v[8*i +: 8]);
  endtask

  task automatic push_random_bytes(input int count);
    for (int i = 0; i < count; i++) push_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic push_hello(input logic [7:0] t, input logic [15:0] ver, input logic [31:0] peer,
                            input int nname);
    push_be(64'(7 + nname), 4);
    push_byte(t);
    push_be(64'(ver), 2);
    push_be(64'(peer), 4);
    push_random_bytes(nname);
  endtask

  task automatic push_clip(input logic [7:0] t, input logic [63:0] stamp, input logic [7:0] fl,
                           input int nmime, input int ndata);
    push_be(64'(12 + nmime + ndata), 4);
    push_byte(t);
    push_be(stamp, 8);
    push_byte(fl);
    push_be(64'(nmime), 2);
    push_random_bytes(nmime + ndata);
  endtask

  task automatic push_plain(input logic [7:0] t, input int nbody);
    push_be(64'(1 + nbody), 4);
    push_byte(t);
    push_random_bytes(nbody);
  endtask

  task automatic push_random_frame();
    logic [7:0] t;
    int         pick;
    pick = int'($urandom_range(0, 99));
    if (pick < 35) t = hello_code_q;
    else if (pick < 70) t = clip_code_q;
    else if (pick < 85) t = synced_code_q;
    else begin
      t = 8'($urandom_range(0, 255));
      while (classify(t) != lfp_pkg::ST_SKIP) t = 8'($urandom_range(0, 255));
    end
    case (classify(t))
      lfp_pkg::ST_HELLO_HDR:
        push_hello(t, 16'($urandom), $urandom, int'($urandom_range(0, 8)));
      lfp_pkg::ST_CLIP_HDR:
        push_clip(t, {$urandom, $urandom}, 8'($urandom),
                  ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 6)),
                  ($urandom_range(0, 3) == 0) ? int'($urandom_range(11, 40))
                                              : int'($urandom_range(0, 10)));
      default: push_plain(t, int'($urandom_range(0, 6)));
    endcase
  endtask

  task automatic push_random_frames(input int target);
    int stop_at;
    stop_at = bytes_queued + target;
    while (bytes_queued < stop_at) push_random_frame();
  endtask

  // ends the stream with one frame that breaks it for good
  task automatic push_breaking_frame();
    logic [32:0] lim;
    int          nmime;
    int          nbody;
    lim = {1'b0, max_clip_q} + lfp_pkg::LIMIT_OVERHEAD + lfp_pkg::MIME_ALLOWANCE;
    case ($urandom_range(0, 4))
      0: push_be(64'd0, 4);
      1: begin
        if (lim < 33'h1_0000_0000) push_be(64'(lim + 33'd1), 4);
        else push_be(64'd0, 4);
      end
      2: begin
        nbody = int'($urandom_range(0, 5));
        push_be(64'(1 + nbody), 4);
        push_byte(hello_code_q);
        push_random_bytes(nbody);
      end
      3: begin
        nbody = int'($urandom_range(0, 10));
        push_be(64'(1 + nbody), 4);
        push_byte(clip_code_q);
        push_random_bytes(nbody);
      end
      default: begin
        nmime = int'($urandom_range(1, 5));
        nbody = int'($urandom_range(0, nmime - 1));
        push_be(64'(12 + nbody), 4);
        push_byte(clip_code_q);
        push_random_bytes(9);
        push_be(64'(nmime), 2);
        push_random_bytes(nbody);
      end
    endcase
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (rx_stream.size() != 0 || in_valid_i || expected_events.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [lfp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [lfp_pkg::CFG_DAT_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      lfp_pkg::CFG_MAX_CLIP:    max_clip_q = val;
      lfp_pkg::CFG_HELLO_CODE:  hello_code_q = val[7:0];
      lfp_pkg::CFG_CLIP_CODE:   clip_code_q = val[7:0];
      lfp_pkg::CFG_SYNCED_CODE: synced_code_q = val[7:0];
      default: begin
      end
    endcase
  endtask

  task automatic configure(input logic [31:0] mc, input logic [7:0] hc, input logic [7:0] cc,
                           input logic [7:0] sc);
    write_reg(lfp_pkg::CFG_MAX_CLIP, mc);
    write_reg(lfp_pkg::CFG_HELLO_CODE, {24'd0, hc});
    write_reg(lfp_pkg::CFG_CLIP_CODE, {24'd0, cc});
    write_reg(lfp_pkg::CFG_SYNCED_CODE, {24'd0, sc});
  endtask

  initial begin
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // defaults: field extremes, every frame kind, synced with a body, unknown types
    push_hello(hello_code_q, 16'hffff, 32'hffff_ffff, 0);
    push_hello(hello_code_q, 16'h0000, 32'h0000_0000, 2);
    push_clip(clip_code_q, 64'h8000_0000_0000_0000, 8'hff, 0, 0);
    push_clip(clip_code_q, 64'h7fff_ffff_ffff_ffff, 8'h00, 2, 3);
    push_plain(synced_code_q, 0);
    push_plain(synced_code_q, 3);
    push_plain(8'h00, 0);
    push_plain(8'hff, 2);
    wait_drained();
    long_hold_req = 1'b1;
    push_random_frames(450);
    wait_drained();

    // smallest limit
    configure(32'd0, 8'h00, 8'hff, 8'h80);
    push_random_frames(400);
    wait_drained();

    // largest limit, all type codes equal
    configure(32'hffff_ffff, 8'h55, 8'h55, 8'h55);
    push_random_frames(400);
    wait_drained();

    // hello and clip share a code
    configure($urandom, 8'haa, 8'haa, 8'h11);
    push_random_frames(300);
    wait_drained();

    // last part: no idling, then a broken stream followed by noise
    idle_on = 1'b0;
    configure($urandom, 8'($urandom_range(0, 80)), 8'($urandom_range(81, 160)),
              8'($urandom_range(161, 255)));
    push_random_frames(450);
    push_breaking_frame();
    push_random_bytes(40);

    do @(posedge clk_i);
    while (rx_stream.size() != 0 || in_valid_i || expected_events.size() != 0);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && expected_events.size() == 0) begin
      $display("PASS length_prefixed_frame_parser_core");
    end else begin
      $display("FAIL length_prefixed_frame_parser_core");
    end
    $finish;
  end

endmodule
`default_nettype wire
